// ===== sv/vrt_pkg.sv =====
// ---------------------------------------------------------------------------
// vrt_pkg: shared types and constants for the voxel ray traversal unit
// Holds the fixed-point formats, the job record that goes from the setup
// front end to the walker, and the saturating add of t values.
// ---------------------------------------------------------------------------
package vrt_pkg;

  // t values are unsigned Q10.16; all ones stands for infinity
  localparam int T_W = 26;
  localparam logic [T_W-1:0] T_INF = {T_W{1'b1}};

  // cell coordinates carry sign and headroom past the largest grid
  localparam int C_W = 10;

  typedef logic [T_W-1:0] tval_t;
  typedef logic signed [C_W-1:0] coord_t;

  // one queued request: a map write or a fully set-up ray
  typedef struct packed {
    logic       is_cast;
    logic [5:0] wx;
    logic [5:0] wy;
    logic [5:0] wz;
    logic       wbit;
    coord_t     x;
    coord_t     y;
    coord_t     z;
    logic       nx;
    logic       ny;
    logic       nz;
    tval_t      tdx;
    tval_t      tdy;
    tval_t      tdz;
    tval_t      tmx;
    tval_t      tmy;
    tval_t      tmz;
    logic [23:0] limit;
  } job_t;

  // add two t values, saturating at infinity
  function automatic tval_t sat_add(input tval_t a, input tval_t b);
    logic [T_W:0] s;
    begin
      s = {1'b0, a} + {1'b0, b};
      sat_add = (s >= {1'b0, T_INF}) ? T_INF : s[T_W-1:0];
    end
  endfunction

endpackage

// ===== sv/vrt_ram.sv =====
// ---------------------------------------------------------------------------
// vrt_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ---------------------------------------------------------------------------
module vrt_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/vrt_front.sv =====
// ---------------------------------------------------------------------------
// vrt_front: request intake and ray setup
// Latches a request; for a cast it squares the direction, takes the length by a
// bit-serial square root, then derives each axis step by serial division
// and the first boundary distance by one multiply.
// ---------------------------------------------------------------------------
module vrt_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  logic                cmd,
  input  logic [5:0]          cell_x,
  input  logic [5:0]          cell_y,
  input  logic [5:0]          cell_z,
  input  logic                solid_bit,
  input  logic signed [15:0]  origin_x,
  input  logic signed [15:0]  origin_y,
  input  logic signed [15:0]  origin_z,
  input  logic signed [15:0]  dir_x,
  input  logic signed [15:0]  dir_y,
  input  logic signed [15:0]  dir_z,
  input  logic [15:0]         reach,
  input  logic                full,
  output logic                busy,
  output logic                push,
  output vrt_pkg::job_t       job
);
  import vrt_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SQ   = 3'd1;
  localparam logic [2:0] S_SQRT = 3'd2;
  localparam logic [2:0] S_DIV  = 3'd3;
  localparam logic [2:0] S_MUL  = 3'd4;
  localparam logic [2:0] S_TM   = 3'd5;
  localparam logic [2:0] S_PUSH = 3'd6;

  logic [2:0]         state;
  logic [4:0]         cnt;
  logic [1:0]         ax;
  logic signed [15:0] o_r [3];
  logic signed [15:0] d_r [3];
  logic [31:0]        sq_r;
  logic [31:0]        sum;
  logic [31:0]        rad;
  logic [33:0]        rem;
  logic [31:0]        root;
  logic [31:0]        q;
  logic [15:0]        drem;
  logic [34:0]        prod;
  tval_t              td_cur;

  logic signed [15:0] d_sel;
  logic signed [15:0] d_sq;
  logic [15:0]        mag;
  logic [35:0]        s_cur;
  logic [35:0]        s_trial;
  logic               s_ge;
  logic [16:0]        q_cur;
  logic               q_ge;
  logic [16:0]        q_dif;
  tval_t              td_sat;
  logic [7:0]         frac;
  logic [8:0]         bdist;
  tval_t              tm_new;
  logic [31:0]        sq_next;

  // per-axis operands and one step of each serial unit
  always_comb begin
    d_sel   = d_r[ax];
    d_sq    = (cnt[1:0] == 2'd3) ? 16'sd0 : d_r[cnt[1:0]];
    sq_next = 32'($signed(d_sq) * $signed(d_sq));
    mag     = d_sel[15] ? 16'(-d_sel) : d_sel;
    s_cur   = {rem, rad[31:30]};
    s_trial = {2'b00, root, 2'b01};
    s_ge    = s_cur >= s_trial;
    // the first division step reads the root as its dividend
    q_cur   = (state == S_DIV && cnt == 5'd0) ? {16'd0, root[31]} : {drem, q[31]};
    q_ge    = q_cur >= {1'b0, mag};
    q_dif   = q_cur - {1'b0, mag};
    td_sat  = (q >= {6'd0, T_INF}) ? T_INF : q[T_W-1:0];
    frac    = o_r[ax][7:0];
    bdist   = d_sel[15] ? {1'b0, frac} : (9'd256 - {1'b0, frac});
    if (td_cur == T_INF || prod[34:8] >= {1'b0, T_INF}) begin
      tm_new = T_INF;
    end else begin
      tm_new = prod[T_W+7:8];
    end
  end

  assign busy = (state != S_IDLE);
  assign push = (state == S_PUSH) && !full;

  // sequence one request through setup
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            o_r[0] <= origin_x; o_r[1] <= origin_y; o_r[2] <= origin_z;
            d_r[0] <= dir_x;    d_r[1] <= dir_y;    d_r[2] <= dir_z;
            job.is_cast <= cmd;
            job.wx <= cell_x; job.wy <= cell_y; job.wz <= cell_z;
            job.wbit <= solid_bit;
            job.x <= coord_t'($signed(origin_x[15:8]));
            job.y <= coord_t'($signed(origin_y[15:8]));
            job.z <= coord_t'($signed(origin_z[15:8]));
            job.nx <= !(dir_x > 16'sd0);
            job.ny <= !(dir_y > 16'sd0);
            job.nz <= !(dir_z > 16'sd0);
            job.limit <= {reach, 8'd0};
            cnt <= '0;
            sum <= '0;
            state <= cmd ? S_SQ : S_PUSH;
          end
        end
        S_SQ: begin
          // square one axis a cycle, accumulate the previous square
          sq_r <= sq_next;
          if (cnt != 5'd0) begin
            sum <= sum + sq_r;
          end
          if (cnt == 5'd3) begin
            rad   <= sum + sq_r;
            rem   <= '0;
            root  <= '0;
            cnt   <= '0;
            state <= S_SQRT;
          end else begin
            cnt <= cnt + 5'd1;
          end
        end
        S_SQRT: begin
          // one root bit a cycle; low input half is all zeros
          if (s_ge) begin
            rem  <= 34'(s_cur - s_trial);
            root <= {root[30:0], 1'b1};
          end else begin
            rem  <= s_cur[33:0];
            root <= {root[30:0], 1'b0};
          end
          rad <= {rad[29:0], 2'b00};
          cnt <= cnt + 5'd1;
          if (cnt == 5'd31) begin
            ax    <= 2'd0;
            drem  <= '0;
            state <= S_DIV;
          end
        end
        S_DIV: begin
          if (cnt == 5'd0 && d_sel == 16'sd0) begin
            // zero component: infinite step on this axis
            td_cur <= T_INF;
            prod   <= '0;
            state  <= S_TM;
          end else begin
            if (cnt == 5'd0) begin
              q <= {root[30:0], q_ge};
            end else begin
              q <= {q[30:0], q_ge};
            end
            drem <= q_ge ? q_dif[15:0] : q_cur[15:0];
            cnt  <= cnt + 5'd1;
            if (cnt == 5'd31) begin
              state <= S_MUL;
            end
          end
        end
        S_MUL: begin
          td_cur <= td_sat;
          prod   <= 35'(bdist * td_sat);
          state  <= S_TM;
        end
        S_TM: begin
          case (ax)
            2'd0: begin job.tdx <= td_cur; job.tmx <= tm_new; end
            2'd1: begin job.tdy <= td_cur; job.tmy <= tm_new; end
            default: begin job.tdz <= td_cur; job.tmz <= tm_new; end
          endcase
          cnt  <= '0;
          drem <= '0;
          if (ax == 2'd2) begin
            state <= S_PUSH;
          end else begin
            ax    <= ax + 2'd1;
            state <= S_DIV;
          end
        end
        S_PUSH: begin
          if (!full) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/vrt_queue.sv =====
// ---------------------------------------------------------------------------
// vrt_queue: two-entry request queue between setup and walker
// ---------------------------------------------------------------------------
module vrt_queue (
  input  logic          clk,
  input  logic          rst,
  input  logic          push,
  input  vrt_pkg::job_t job_in,
  input  logic          pop,
  output vrt_pkg::job_t job_out,
  output logic          full,
  output logic          empty
);
  import vrt_pkg::*;

  job_t       ent [2];
  logic       wp;
  logic       rp;
  logic [1:0] count;

  assign full    = (count == 2'd2);
  assign empty   = (count == 2'd0);
  assign job_out = ent[rp];

  // store on push, advance on pop
  always_ff @(posedge clk) begin
    if (push) begin
      ent[wp] <= job_in;
    end
    if (rst) begin
      wp    <= 1'b0;
      rp    <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wp <= ~wp;
      end
      if (pop) begin
        rp <= ~rp;
      end
      count <= count + {1'b0, push} - {1'b0, pop};
    end
  end

endmodule

// ===== sv/vrt_back.sv =====
// ---------------------------------------------------------------------------
// vrt_back: solid map and DDA walker
// Clears the map after reset, performs map writes, and walks each ray
// cell by cell: check and read, then test and step.
// ---------------------------------------------------------------------------
module vrt_back #(
  parameter int GRID_X_BITS = 6,
  parameter int GRID_Y_BITS = 6,
  parameter int GRID_Z_BITS = 6,
  parameter int MAX_STEPS   = 900
) (
  input  logic          clk,
  input  logic          rst,
  input  vrt_pkg::job_t job,
  input  logic          empty,
  output logic          pop,
  output logic          clearing,
  output logic          done,
  output logic          hit,
  output logic [5:0]    hit_x,
  output logic [5:0]    hit_y,
  output logic [5:0]    hit_z,
  output logic [5:0]    prev_x,
  output logic [5:0]    prev_y,
  output logic [5:0]    prev_z
);
  import vrt_pkg::*;

  localparam int AW = GRID_X_BITS + GRID_Y_BITS + GRID_Z_BITS;
  localparam int GW = $clog2(MAX_STEPS + 1);
  localparam logic [GW-1:0] GMAX = GW'(MAX_STEPS);
  localparam coord_t XLIM = coord_t'(1 << GRID_X_BITS);
  localparam coord_t YLIM = coord_t'(1 << GRID_Y_BITS);
  localparam coord_t ZLIM = coord_t'(1 << GRID_Z_BITS);

  localparam logic [1:0] S_CLR   = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_CHECK = 2'd2;
  localparam logic [1:0] S_TEST  = 2'd3;

  logic [1:0]    state;
  logic [AW-1:0] clr_addr;
  coord_t        x, y, z, lx, ly, lz;
  logic          nx, ny, nz;
  tval_t         tdx, tdy, tdz, tmx, tmy, tmz, travel;
  logic [23:0]   limit;
  logic [GW-1:0] guard;

  logic          we;
  logic [AW-1:0] waddr;
  logic          wdata;
  logic          re;
  logic [AW-1:0] raddr;
  logic          rdata;
  logic [7:0]    wx8, wy8, wz8;
  logic          in_grid;

  vrt_ram #(.WIDTH(1), .DEPTH(1 << AW)) u_map (
    .clk  (clk),
    .we   (we),
    .waddr(waddr),
    .wdata(wdata),
    .re   (re),
    .raddr(raddr),
    .rdata(rdata)
  );

  // map port control
  always_comb begin
    wx8     = {2'b00, job.wx};
    wy8     = {2'b00, job.wy};
    wz8     = {2'b00, job.wz};
    pop     = (state == S_IDLE) && !empty;
    in_grid = !x[C_W-1] && !y[C_W-1] && !z[C_W-1] && (x < XLIM) && (y < YLIM) && (z < ZLIM);
    re      = (state == S_CHECK);
    raddr   = {x[GRID_X_BITS-1:0], y[GRID_Y_BITS-1:0], z[GRID_Z_BITS-1:0]};
    if (state == S_CLR) begin
      we    = 1'b1;
      waddr = clr_addr;
      wdata = 1'b0;
    end else begin
      we    = pop && !job.is_cast;
      waddr = {wx8[GRID_X_BITS-1:0], wy8[GRID_Y_BITS-1:0], wz8[GRID_Z_BITS-1:0]};
      wdata = job.wbit;
    end
  end

  assign clearing = (state == S_CLR);

  // walk control and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLR;
      clr_addr <= '0;
      done     <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        S_CLR: begin
          clr_addr <= clr_addr + 1'b1;
          if (clr_addr == {AW{1'b1}}) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            if (job.is_cast) begin
              x <= job.x; y <= job.y; z <= job.z;
              lx <= job.x; ly <= job.y; lz <= job.z;
              nx <= job.nx; ny <= job.ny; nz <= job.nz;
              tdx <= job.tdx; tdy <= job.tdy; tdz <= job.tdz;
              tmx <= job.tmx; tmy <= job.tmy; tmz <= job.tmz;
              limit  <= job.limit;
              travel <= '0;
              guard  <= '0;
              state  <= S_CHECK;
            end else begin
              // map write: report an empty result
              done <= 1'b1;
              hit  <= 1'b0;
              hit_x <= '0; hit_y <= '0; hit_z <= '0;
              prev_x <= '0; prev_y <= '0; prev_z <= '0;
            end
          end
        end
        S_CHECK: begin
          if (guard == GMAX || travel > {2'b00, limit} || !in_grid) begin
            done <= 1'b1;
            hit  <= 1'b0;
            hit_x <= '0; hit_y <= '0; hit_z <= '0;
            prev_x <= '0; prev_y <= '0; prev_z <= '0;
            state <= S_IDLE;
          end else begin
            state <= S_TEST;
          end
        end
        S_TEST: begin
          if (rdata) begin
            done   <= 1'b1;
            hit    <= 1'b1;
            hit_x  <= x[5:0];  hit_y  <= y[5:0];  hit_z  <= z[5:0];
            prev_x <= lx[5:0]; prev_y <= ly[5:0]; prev_z <= lz[5:0];
            state  <= S_IDLE;
          end else begin
            // advance across the nearest boundary
            lx <= x; ly <= y; lz <= z;
            guard <= guard + 1'b1;
            if (tmx < tmy && tmx < tmz) begin
              x      <= nx ? x - coord_t'(1) : x + coord_t'(1);
              travel <= tmx;
              tmx    <= sat_add(tmx, tdx);
            end else if (tmy < tmz) begin
              y      <= ny ? y - coord_t'(1) : y + coord_t'(1);
              travel <= tmy;
              tmy    <= sat_add(tmy, tdy);
            end else begin
              z      <= nz ? z - coord_t'(1) : z + coord_t'(1);
              travel <= tmz;
              tmz    <= sat_add(tmz, tdz);
            end
            state <= S_CHECK;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== sv/voxel_ray_traversal_unit.sv =====
// ---------------------------------------------------------------------------
// voxel_ray_traversal_unit: solid voxel map with a 3D DDA ray caster
// Requests are taken while busy is low; each gives one result on done.
// ---------------------------------------------------------------------------
// After reset the map is cleared one cell a cycle, all 2^(GRID_X_BITS +
// GRID_Y_BITS + GRID_Z_BITS) cells (262144 at the defaults), with busy held
// high. The walker writes the map as it pops a write request and reports its
// result. A cast goes through setup (the squares, the bit-serial root, and per
// axis the serial divider and its multiply), then the walker checks and reads
// each visited cell through the single registered read port of the map and
// then tests and steps. A two-entry queue lets the setup of the next request
// overlap the walk of the current one. Results are shown on done for one
// cycle and cannot be held off.
module voxel_ray_traversal_unit #(
  parameter int GRID_X_BITS = 6,
  parameter int GRID_Y_BITS = 6,
  parameter int GRID_Z_BITS = 6,
  parameter int MAX_STEPS   = 900
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               cmd,
  input  logic [5:0]         cell_x,
  input  logic [5:0]         cell_y,
  input  logic [5:0]         cell_z,
  input  logic               solid_bit,
  input  logic signed [15:0] origin_x,
  input  logic signed [15:0] origin_y,
  input  logic signed [15:0] origin_z,
  input  logic signed [15:0] dir_x,
  input  logic signed [15:0] dir_y,
  input  logic signed [15:0] dir_z,
  input  logic [15:0]        reach,
  output logic               done,
  output logic               hit,
  output logic [5:0]         hit_x,
  output logic [5:0]         hit_y,
  output logic [5:0]         hit_z,
  output logic [5:0]         prev_x,
  output logic [5:0]         prev_y,
  output logic [5:0]         prev_z
);
  import vrt_pkg::*;

  logic f_busy;
  logic q_push;
  logic q_pop;
  logic q_full;
  logic q_empty;
  logic clearing;
  job_t f_job;
  job_t q_job;

  // hold off requests during setup and the map clear
  assign busy = f_busy || clearing;

  vrt_front u_front (
    .clk      (clk),
    .rst      (rst),
    .start    (start && !clearing),
    .cmd      (cmd),
    .cell_x   (cell_x),
    .cell_y   (cell_y),
    .cell_z   (cell_z),
    .solid_bit(solid_bit),
    .origin_x (origin_x),
    .origin_y (origin_y),
    .origin_z (origin_z),
    .dir_x    (dir_x),
    .dir_y    (dir_y),
    .dir_z    (dir_z),
    .reach    (reach),
    .full     (q_full),
    .busy     (f_busy),
    .push     (q_push),
    .job      (f_job)
  );

  vrt_queue u_queue (
    .clk    (clk),
    .rst    (rst),
    .push   (q_push),
    .job_in (f_job),
    .pop    (q_pop),
    .job_out(q_job),
    .full   (q_full),
    .empty  (q_empty)
  );

  vrt_back #(
    .GRID_X_BITS(GRID_X_BITS),
    .GRID_Y_BITS(GRID_Y_BITS),
    .GRID_Z_BITS(GRID_Z_BITS),
    .MAX_STEPS  (MAX_STEPS)
  ) u_back (
    .clk     (clk),
    .rst     (rst),
    .job     (q_job),
    .empty   (q_empty),
    .pop     (q_pop),
    .clearing(clearing),
    .done    (done),
    .hit     (hit),
    .hit_x   (hit_x),
    .hit_y   (hit_y),
    .hit_z   (hit_z),
    .prev_x  (prev_x),
    .prev_y  (prev_y),
    .prev_z  (prev_z)
  );

  // an accepted request keeps the block busy in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy) else $error("busy low after accept");

  // the queue never takes a request while full
  a_no_overflow: assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue overflow");

  // no result while the map is being cleared
  a_no_done_clear: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !done) else $error("result during map clear");

  // nothing leaves the queue while it is empty
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("queue underflow");

endmodule
